@@ rtl/dvfs_level_vote_arbiter_core_macros.svh @@
// ----------------------------------------------------------------------------
// DVFS level vote arbiter: assertion macros
// Shared concurrent assertion forms. Each expects i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef DVFS_LEVEL_VOTE_ARBITER_CORE_MACROS_SVH
`define DVFS_LEVEL_VOTE_ARBITER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DVLA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DVLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dvla_pkg.sv @@
// ----------------------------------------------------------------------------
// DVFS level vote arbiter package
// Field widths, function codes, controller/datapath interface types and
// small helper functions shared by the arbiter modules.
// ----------------------------------------------------------------------------
package dvla_pkg;

    // Field widths.
    localparam int FUNC_W  = 3;
    localparam int IDX_W   = 5;
    localparam int KHZ_W   = 22;
    localparam int USERS_W = 4;
    localparam int LCNT_W  = 6;
    // Counts and scan positions up to the largest table depth.
    localparam int CNT_W   = 7;

    // Default table depth.
    localparam int MAX_LEVELS_DEF = 32;

    // Reset value of the level count register.
    localparam logic [LCNT_W-1:0] LCNT_RESET = LCNT_W'(32);

    localparam logic [IDX_W-1:0]   IDX_MAX   = '1;
    localparam logic [USERS_W-1:0] USERS_MAX = '1;

    // Function codes.
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ATTACH  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_REQUEST = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_QUERY   = 3'd4;

    // Voter codes.
    localparam logic VOTER_OWNER  = 1'b0;
    localparam logic VOTER_SHARED = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic scan_clear;
        logic scan_step;
        logic apply;
        logic query_rd;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_req;
        logic scan_done;
    } t_dp_sts;

    // Saturate a count-wide value to the largest level index.
    function automatic logic [IDX_W-1:0] sat_idx(input logic [CNT_W-1:0] v);
        logic [IDX_W-1:0] r;
        r = (v > CNT_W'(IDX_MAX)) ? IDX_MAX : v[IDX_W-1:0];
        return r;
    endfunction

    // Lower of two level indexes.
    function automatic logic [IDX_W-1:0] min_idx(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
        logic [IDX_W-1:0] r;
        r = (a < b) ? a : b;
        return r;
    endfunction

endpackage

@@ rtl/dvfs_level_vote_arbiter_core.sv @@
// ----------------------------------------------------------------------------
// DVFS level vote arbiter core
// Two voters share one performance level over a table of levels ordered
// fastest first; the driven level and its frequency are reported per item.
// ----------------------------------------------------------------------------
// Usage:
//   An item is transferred in at a clock edge with start high and busy low.
//   Every item yields exactly one result, shown on the o_ result ports for a
//   single cycle with o_result_valid high; the receiver cannot stall it.
//   The level count register is written through cfg_valid/cfg_ready, which
//   is always ready; write it only while the block is idle.
// Sequencing:
//   Every item passes through the update, the table read of the driven level
//   and the result strobe, and a new item is taken only back in idle. A
//   shared-voter request first walks the level table through its single read
//   port, one entry per cycle, until the first entry at or below the target
//   or the end of the usable levels.
// Reset:
//   Reset clears the vote state and sets the level count to 32. The level
//   table is not cleared; every entry must be loaded before it is read.
// ----------------------------------------------------------------------------
module dvfs_level_vote_arbiter_core
    import dvla_pkg::*;
#(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Item channel.
    input  logic               start,
    output logic               busy,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic               i_voter,
    input  logic [IDX_W-1:0]   i_level_index,
    input  logic [KHZ_W-1:0]   i_target_khz,
    // Configuration channel.
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LCNT_W-1:0]  i_cfg_level_count,
    // Result channel.
    output logic               o_result_valid,
    output logic [IDX_W-1:0]   o_perf_level,
    output logic               o_enabled,
    output logic [KHZ_W-1:0]   o_current_khz,
    output logic [USERS_W-1:0] o_user_count
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_cfg_we;

    // The configuration register accepts a transfer in every cycle.
    assign cfg_ready = 1'b1;
    assign w_cfg_we  = cfg_valid && cfg_ready;

    dvla_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    dvla_dpath #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_func            (i_func),
        .i_voter           (i_voter),
        .i_level_index     (i_level_index),
        .i_target_khz      (i_target_khz),
        .i_cfg_we          (w_cfg_we),
        .i_cfg_level_count (i_cfg_level_count),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_perf_level      (o_perf_level),
        .o_enabled         (o_enabled),
        .o_current_khz     (o_current_khz),
        .o_user_count      (o_user_count)
    );

endmodule

@@ rtl/dvla_dpath.sv @@
// ----------------------------------------------------------------------------
// DVFS level vote arbiter datapath
// Holds the level table memory, the vote state, the level count register and
// the frequency-to-level scan, and applies one command per item.
// ----------------------------------------------------------------------------
`include "dvfs_level_vote_arbiter_core_macros.svh"

module dvla_dpath
    import dvla_pkg::*;
#(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Item fields.
    input  logic [FUNC_W-1:0]  i_func,
    input  logic               i_voter,
    input  logic [IDX_W-1:0]   i_level_index,
    input  logic [KHZ_W-1:0]   i_target_khz,
    // Configuration write.
    input  logic               i_cfg_we,
    input  logic [LCNT_W-1:0]  i_cfg_level_count,
    // Controller interface.
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    // Result fields.
    output logic [IDX_W-1:0]   o_perf_level,
    output logic               o_enabled,
    output logic [KHZ_W-1:0]   o_current_khz,
    output logic [USERS_W-1:0] o_user_count
);

    localparam int AW = $clog2(MAX_LEVELS);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEVELS);

    // Level table.
    logic [KHZ_W-1:0] r_table [MAX_LEVELS];
    logic [KHZ_W-1:0] r_rd_data;

    // Latched item.
    logic [FUNC_W-1:0] r_func;
    logic              r_voter;
    logic [IDX_W-1:0]  r_idx;
    logic [KHZ_W-1:0]  r_khz;

    // Configuration and vote state.
    logic [LCNT_W-1:0]  r_level_count;
    logic [IDX_W-1:0]   r_owner;
    logic [IDX_W-1:0]   r_shared;
    logic [USERS_W-1:0] r_users;
    logic [IDX_W-1:0]   r_driven;
    logic               r_enable;

    // Scan state.
    logic [CNT_W-1:0] r_scan_addr;
    logic [CNT_W-1:0] r_cmp_idx;
    logic             r_cmp_vld;

    logic [CNT_W-1:0]   w_n_eff;
    logic [CNT_W-1:0]   w_n_last;
    logic [IDX_W-1:0]   w_last_lvl;
    logic [CNT_W-1:0]   w_q;
    logic [CNT_W-1:0]   w_idx_ext;
    logic               w_scan_issue;
    logic               w_hit;
    logic [IDX_W-1:0]   w_mapped;
    logic               w_rd_en;
    logic [AW-1:0]      w_rd_addr;
    logic [IDX_W-1:0]   w_rel_owner;
    logic [IDX_W-1:0]   w_rel_shared;
    logic [USERS_W-1:0] w_users_dec;

    // Effective count, last level and the clamped query slot.
    assign w_n_eff    = (CNT_W'(r_level_count) > MAX_CNT) ? MAX_CNT
                                                          : CNT_W'(r_level_count);
    assign w_n_last   = w_n_eff - CNT_W'(1);
    assign w_last_lvl = (w_n_eff == '0) ? '0 : sat_idx(w_n_last);
    assign w_q        = (w_n_eff == '0) ? '0 :
                        ((CNT_W'(r_driven) < w_n_last) ? CNT_W'(r_driven) : w_n_last);
    assign w_idx_ext  = CNT_W'(r_idx);

    // Scan: one table read issued per step, compared in the next cycle.
    assign w_scan_issue = i_cmd.scan_step && (r_scan_addr < w_n_eff);
    assign w_hit        = r_cmp_vld && (r_rd_data <= r_khz);
    assign w_mapped     = w_hit ? sat_idx(r_cmp_idx) : w_last_lvl;

    assign o_sts.scan_req  = (i_func == FUNC_REQUEST) && (i_voter == VOTER_SHARED);
    assign o_sts.scan_done = w_hit || (!r_cmp_vld && (r_scan_addr >= w_n_eff));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr <= '0;
            r_cmp_vld   <= 1'b0;
        end else if (i_cmd.scan_clear) begin
            r_scan_addr <= '0;
            r_cmp_vld   <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_cmp_vld <= w_scan_issue;
            if (w_scan_issue) begin
                r_cmp_idx   <= r_scan_addr;
                r_scan_addr <= r_scan_addr + CNT_W'(1);
            end
        end
    end

    // Table read port: scan address or query slot.
    assign w_rd_en   = w_scan_issue || i_cmd.query_rd;
    assign w_rd_addr = i_cmd.query_rd ? w_q[AW-1:0] : r_scan_addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_table[w_rd_addr];
        end
    end

    // Table write port: load items with an in-range slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && (r_func == FUNC_LOAD) && (w_idx_ext < MAX_CNT)) begin
            r_table[w_idx_ext[AW-1:0]] <= r_khz;
        end
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= i_func;
            r_voter <= i_voter;
            r_idx   <= i_level_index;
            r_khz   <= i_target_khz;
        end
    end

    // Level count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_count <= LCNT_RESET;
        end else if (i_cfg_we) begin
            r_level_count <= i_cfg_level_count;
        end
    end

    // Release parks the releasing voter at the last level.
    assign w_rel_owner  = (r_voter == VOTER_OWNER)  ? w_last_lvl : r_owner;
    assign w_rel_shared = (r_voter == VOTER_SHARED) ? w_last_lvl : r_shared;
    assign w_users_dec  = (r_users != '0) ? (r_users - USERS_W'(1)) : '0;

    // Vote state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner  <= '0;
            r_shared <= '0;
            r_users  <= '0;
            r_driven <= '0;
            r_enable <= 1'b0;
        end else if (i_cmd.apply) begin
            case (r_func)
                FUNC_ATTACH: begin
                    if (r_users == '0) begin
                        r_owner  <= r_driven;
                        r_shared <= r_driven;
                    end
                    if (r_users != USERS_MAX) begin
                        r_users <= r_users + USERS_W'(1);
                    end
                    r_enable <= 1'b1;
                end
                FUNC_REQUEST: begin
                    if (r_voter == VOTER_OWNER) begin
                        r_owner <= r_idx;
                        if (r_users > USERS_W'(1)) begin
                            r_driven <= min_idx(r_idx, r_shared);
                        end else begin
                            r_driven <= r_idx;
                        end
                    end else begin
                        r_shared <= w_mapped;
                        r_driven <= min_idx(r_owner, w_mapped);
                    end
                end
                FUNC_RELEASE: begin
                    r_owner  <= w_rel_owner;
                    r_shared <= w_rel_shared;
                    r_users  <= w_users_dec;
                    if (w_users_dec == '0) begin
                        r_enable <= 1'b0;
                    end else begin
                        r_driven <= min_idx(w_rel_owner, w_rel_shared);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result fields.
    assign o_perf_level  = r_driven;
    assign o_enabled     = r_enable;
    assign o_current_khz = r_rd_data;
    assign o_user_count  = r_users;

    // The enable follows the attached user count.
    `DVLA_ASSERT_IMPL(a_enable_users, 1'b1, r_enable == (r_users != '0), "enable/users mismatch")
    // While scanning, a pending compare refers to a valid table entry.
    `DVLA_ASSERT_IMPL(a_cmp_in_range, i_cmd.scan_step && r_cmp_vld, r_cmp_idx < w_n_eff, "cmp range")
    // The query slot always lies inside the table.
    `DVLA_ASSERT_IMPL(a_query_slot, i_cmd.query_rd, w_q < MAX_CNT, "query slot range")

endmodule

@@ rtl/dvla_ctrl.sv @@
// ----------------------------------------------------------------------------
// DVFS level vote arbiter controller
// Sequences one item: capture, optional table scan, state update, table read
// of the driven level, and the one-cycle result strobe.
// ----------------------------------------------------------------------------
`include "dvfs_level_vote_arbiter_core_macros.svh"

module dvla_ctrl
    import dvla_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy,
    output logic    o_result_valid
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = i_sts.scan_req ? S_SCAN : S_APPLY;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: n_state = S_READ;
            S_READ:  n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath commands.
    assign o_cmd.capture    = (r_state == S_IDLE) && i_start;
    assign o_cmd.scan_clear = (r_state == S_IDLE) && i_start && i_sts.scan_req;
    assign o_cmd.scan_step  = (r_state == S_SCAN) && !i_sts.scan_done;
    assign o_cmd.apply      = (r_state == S_APPLY);
    assign o_cmd.query_rd   = (r_state == S_READ);

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = (r_state == S_OUT);

    // A transfer in makes the block busy in the next cycle.
    `DVLA_ASSERT_NEXT(a_start_busy, i_start && !o_busy, o_busy, "start did not raise busy")
    // Each result strobe is a single cycle and returns to idle.
    `DVLA_ASSERT_NEXT(a_out_idle, o_result_valid, r_state == S_IDLE, "strobe not single")
    // The update is always followed by the table read of the driven level.
    `DVLA_ASSERT_NEXT(a_apply_read, o_cmd.apply, o_cmd.query_rd, "apply not followed by read")

endmodule

@@ tb/sv/tb_dvfs_level_vote_arbiter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DVFS level vote arbiter core testbench
// Drives load, attach, request, release, query and unused codes into the core and
// checks every result strobe against a cycle-free prediction of the vote
// state. The run covers several level-count settings and sender idle patterns.
// ----------------------------------------------------------------------------
module tb_dvfs_level_vote_arbiter_core;
    import dvla_pkg::*;

    localparam int NUM_LEVELS      = MAX_LEVELS_DEF;
    localparam int KHZ_TOP         = 4095000;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 48;
    localparam int MAX_REPORTS     = 10;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 165;
    // Highest function code; codes above query change nothing.
    localparam logic [FUNC_W-1:0] FUNC_TOP = 3'd7;

    // One result of the core, in port order.
    typedef struct packed {
        logic [IDX_W-1:0]   perf_level;
        logic               enabled;
        logic [KHZ_W-1:0]   current_khz;
        logic [USERS_W-1:0] user_count;
    } t_vote_status;

    // Tracks the vote state and holds the results still owed by the core.
    class t_vote_scoreboard;
        logic [KHZ_W-1:0]   khz_table [NUM_LEVELS];
        int unsigned        level_count;
        logic [IDX_W-1:0]   owner_req;
        logic [IDX_W-1:0]   shared_req;
        logic [IDX_W-1:0]   driven;
        logic [USERS_W-1:0] users;
        logic               enable_flag;
        t_vote_status       pending [$];
        int unsigned        checked;
        int unsigned        mismatches;
        int unsigned        shared_requests;

        function new();
            foreach (khz_table[i]) khz_table[i] = '0;
            level_count     = LCNT_RESET;
            owner_req       = '0;
            shared_req      = '0;
            driven          = '0;
            users           = '0;
            enable_flag     = 1'b0;
            checked         = 0;
            mismatches      = 0;
            shared_requests = 0;
        endfunction

        function void set_level_count(logic [LCNT_W-1:0] count);
            level_count = count;
        endfunction

        // Counts above the table depth are clipped to the depth.
        function int unsigned usable_levels();
            return (level_count > NUM_LEVELS) ? NUM_LEVELS : level_count;
        endfunction

        // Park level for a release and fallback of the frequency search.
        function logic [IDX_W-1:0] slowest_level();
            int unsigned n;
            n = usable_levels();
            if (n == 0) return '0;
            return (n - 1 > IDX_MAX) ? IDX_MAX : IDX_W'(n - 1);
        endfunction

        // First entry at or below the target, else the slowest level.
        function logic [IDX_W-1:0] level_for_khz(logic [KHZ_W-1:0] khz);
            int unsigned n;
            n = usable_levels();
            for (int unsigned i = 0; i < n; i++) begin
                if (khz_table[i] <= khz) return (i > IDX_MAX) ? IDX_MAX : IDX_W'(i);
            end
            return slowest_level();
        endfunction

        function logic [IDX_W-1:0] faster(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
            return (a < b) ? a : b;
        endfunction

        // Applies one transferred item and queues the status it must produce.
        function void note_item(logic [FUNC_W-1:0] func, logic voter,
                                logic [IDX_W-1:0] idx, logic [KHZ_W-1:0] khz);
            t_vote_status want;
            int unsigned  n;
            int unsigned  q;
            case (func)
                FUNC_LOAD: begin
                    if (idx < NUM_LEVELS) khz_table[idx] = khz;
                end
                FUNC_ATTACH: begin
                    // The first user seeds both votes from the current level.
                    if (users == 0) begin
                        owner_req  = driven;
                        shared_req = driven;
                    end
                    if (users != USERS_MAX) users = users + 1'b1;
                    enable_flag = 1'b1;
                end
                FUNC_REQUEST: begin
                    if (voter == VOTER_OWNER) begin
                        owner_req = idx;
                        driven = (users > 1) ? faster(owner_req, shared_req) : idx;
                    end else begin
                        shared_requests++;
                        shared_req = level_for_khz(khz);
                        driven = faster(owner_req, shared_req);
                    end
                end
                FUNC_RELEASE: begin
                    if (voter == VOTER_OWNER) owner_req = slowest_level();
                    else shared_req = slowest_level();
                    if (users != 0) users = users - 1'b1;
                    if (users == 0) enable_flag = 1'b0;
                    else driven = faster(owner_req, shared_req);
                end
                default: ;
            endcase
            // The reported frequency is clamped to the last usable level.
            n = usable_levels();
            q = (n == 0) ? 0 : ((driven < n - 1) ? driven : n - 1);
            if (q >= NUM_LEVELS) q = NUM_LEVELS - 1;
            want.perf_level  = driven;
            want.enabled     = enable_flag;
            want.current_khz = khz_table[q];
            want.user_count  = users;
            pending.push_back(want);
        endfunction

        // Compares one result strobe with the oldest outstanding status.
        function void check_result(t_vote_status got);
            t_vote_status want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: result with no item outstanding");
                    $display("  actual   level=%0d en=%0b khz=%0d users=%0d",
                             got.perf_level, got.enabled, got.current_khz, got.user_count);
                end
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.perf_level !== want.perf_level || got.enabled !== want.enabled ||
                got.current_khz !== want.current_khz || got.user_count !== want.user_count) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: result %0d: expected level=%0d en=%0b khz=%0d users=%0d",
                             checked, want.perf_level, want.enabled, want.current_khz,
                             want.user_count);
                    $display("ERROR: result %0d: actual   level=%0d en=%0b khz=%0d users=%0d",
                             checked, got.perf_level, got.enabled, got.current_khz,
                             got.user_count);
                end
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [FUNC_W-1:0]  i_func;
    logic               i_voter;
    logic [IDX_W-1:0]   i_level_index;
    logic [KHZ_W-1:0]   i_target_khz;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [LCNT_W-1:0]  i_cfg_level_count;
    logic               o_result_valid;
    logic [IDX_W-1:0]   o_perf_level;
    logic               o_enabled;
    logic [KHZ_W-1:0]   o_current_khz;
    logic [USERS_W-1:0] o_user_count;

    t_vote_scoreboard sb;
    int unsigned      gap_percent;
    int unsigned      counted;
    int unsigned      transfers;
    int unsigned      count_writes;
    int unsigned      cycle_count;

    dvfs_level_vote_arbiter_core #(
        .MAX_LEVELS (NUM_LEVELS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_func            (i_func),
        .i_voter           (i_voter),
        .i_level_index     (i_level_index),
        .i_target_khz      (i_target_khz),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .i_cfg_level_count (i_cfg_level_count),
        .o_result_valid    (o_result_valid),
        .o_perf_level      (o_perf_level),
        .o_enabled         (o_enabled),
        .o_current_khz     (o_current_khz),
        .o_user_count      (o_user_count)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Monitor: results, item transfers and register writes at each edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid)
                sb.check_result({o_perf_level, o_enabled, o_current_khz, o_user_count});
            if (start && !busy) begin
                transfers++;
                sb.note_item(i_func, i_voter, i_level_index, i_target_khz);
            end
            if (cfg_valid && cfg_ready) sb.set_level_count(i_cfg_level_count);
        end
    end

    // Watchdog on the total run length.
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge i_clk);
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, sb.pending.size());
        $display("Verification failed");
        $finish;
    end

    // Presents one item, with an optional idle gap first, until it transfers.
    task automatic send_item(logic [FUNC_W-1:0] func, logic voter,
                             logic [IDX_W-1:0] idx, logic [KHZ_W-1:0] khz);
        int unsigned idle;
        if ($urandom_range(99) < gap_percent) begin
            idle = ($urandom_range(3) == 0) ? $urandom_range(40, 1) : $urandom_range(4, 1);
            start <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_func        <= func;
        i_voter       <= voter;
        i_level_index <= idx;
        i_target_khz  <= khz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (func <= FUNC_RELEASE) counted++;
    endtask

    // Stops issuing and waits until every owed result has been seen.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // Writes the level count once the core has gone quiet.
    task automatic write_level_count(logic [LCNT_W-1:0] count);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_valid         <= 1'b1;
        i_cfg_level_count <= count;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        count_writes++;
    endtask

    // Loads all slots, fastest first if descending, else random; slot 0 goes first so no read is stale.
    task automatic load_table(bit descending);
        int          khz;
        logic [KHZ_W-1:0] value;
        khz = KHZ_TOP;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            value = descending ? KHZ_W'(khz) : KHZ_W'($urandom_range(KHZ_TOP));
            send_item(FUNC_LOAD, 1'($urandom_range(1)), IDX_W'(i), value);
            // A zero step leaves equal neighbors now and then.
            khz = khz - int'($urandom_range(150000));
            if (khz < 0) khz = 0;
        end
    endtask

    // Targets mostly sit on or next to a table entry to probe the search edge.
    function automatic logic [KHZ_W-1:0] pick_khz();
        int unsigned slot;
        int          khz;
        slot = $urandom_range(NUM_LEVELS - 1);
        case ($urandom_range(4))
            0: khz = $urandom_range(KHZ_TOP);
            1: khz = $urandom_range(1) ? KHZ_TOP : 0;
            default: khz = int'(sb.khz_table[slot]) + int'($urandom_range(2)) - 1;
        endcase
        if (khz < 0) khz = 0;
        if (khz > KHZ_TOP) khz = KHZ_TOP;
        return KHZ_W'(khz);
    endfunction

    // Attach a few users, vote, then release roughly as many.
    task automatic run_session();
        int unsigned attaches;
        int unsigned releases;
        int unsigned pick;
        attaches = ($urandom_range(7) == 0) ? $urandom_range(17, 4) : $urandom_range(3, 1);
        releases = attaches;
        if ($urandom_range(7) == 0) releases = attaches + $urandom_range(2) - 1;
        repeat (attaches)
            send_item(FUNC_ATTACH, 1'($urandom_range(1)), IDX_W'($urandom_range(31)),
                      pick_khz());
        repeat ($urandom_range(12, 1)) begin
            pick = $urandom_range(9);
            if (pick < 4)
                send_item(FUNC_REQUEST, VOTER_OWNER, IDX_W'($urandom_range(31)), pick_khz());
            else if (pick < 8)
                send_item(FUNC_REQUEST, VOTER_SHARED, IDX_W'($urandom_range(31)), pick_khz());
            else if (pick < 9)
                send_item(FUNC_QUERY, 1'($urandom_range(1)), IDX_W'($urandom_range(31)),
                          pick_khz());
            else
                send_item(FUNC_LOAD, 1'($urandom_range(1)), IDX_W'($urandom_range(31)),
                          pick_khz());
        end
        repeat (releases)
            send_item(FUNC_RELEASE, 1'($urandom_range(1)), IDX_W'($urandom_range(31)),
                      pick_khz());
    endtask

    // Mostly well-formed sessions, some unrelated single commands.
    task automatic random_traffic(int unsigned quota);
        int unsigned goal;
        goal = counted + quota;
        while (counted < goal) begin
            if ($urandom_range(9) < 8)
                run_session();
            else
                send_item(FUNC_W'($urandom_range(FUNC_TOP)), 1'($urandom_range(1)),
                          IDX_W'($urandom_range(31)), pick_khz());
        end
    endtask

    // Main sequence.
    initial begin
        logic [LCNT_W-1:0] phase_count [NUM_PHASES];
        int unsigned       phase_idle [4];
        logic [KHZ_W-1:0]  probe_khz;

        sb                = new();
        gap_percent       = 0;
        counted           = 0;
        transfers         = 0;
        count_writes      = 0;
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_func            = FUNC_QUERY;
        i_voter           = VOTER_OWNER;
        i_level_index     = '0;
        i_target_khz      = '0;
        cfg_valid         = 1'b0;
        i_cfg_level_count = LCNT_RESET;

        phase_count[0] = LCNT_W'(1);
        phase_count[1] = LCNT_W'(0);
        phase_count[2] = LCNT_W'(63);
        phase_count[3] = LCNT_W'(33);
        phase_count[4] = LCNT_W'($urandom_range(31, 2));
        phase_count[5] = LCNT_W'(32);
        phase_count[6] = LCNT_W'($urandom_range(63));
        phase_count[7] = LCNT_W'(16);
        phase_idle[0]  = 0;
        phase_idle[1]  = 53;
        phase_idle[2]  = 0;
        phase_idle[3]  = 34;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset level count, back to back.
        load_table(1'b1);
        send_item(FUNC_QUERY, VOTER_OWNER, '0, '0);
        for (int f = FUNC_QUERY + 1; f <= FUNC_TOP; f++)
            send_item(FUNC_W'(f), 1'($urandom_range(1)), IDX_W'($urandom_range(31)),
                      KHZ_W'($urandom_range(KHZ_TOP)));
        // Owner votes with no user attached drive their index directly.
        send_item(FUNC_REQUEST, VOTER_OWNER, IDX_MAX, '0);
        send_item(FUNC_REQUEST, VOTER_OWNER, '0, KHZ_W'(KHZ_TOP));
        send_item(FUNC_ATTACH, VOTER_OWNER, '0, '0);
        send_item(FUNC_REQUEST, VOTER_OWNER, IDX_MAX, '0);
        send_item(FUNC_ATTACH, VOTER_SHARED, '0, '0);
        send_item(FUNC_REQUEST, VOTER_OWNER, IDX_W'(20), '0);
        send_item(FUNC_REQUEST, VOTER_SHARED, '0, KHZ_W'(KHZ_TOP));
        // A zero slowest entry matches a zero target; a nonzero one does not.
        send_item(FUNC_LOAD, VOTER_OWNER, IDX_MAX, '0);
        send_item(FUNC_REQUEST, VOTER_SHARED, '0, '0);
        send_item(FUNC_REQUEST, VOTER_OWNER, IDX_MAX, '0);
        send_item(FUNC_LOAD, VOTER_SHARED, IDX_MAX, KHZ_W'(1));
        send_item(FUNC_REQUEST, VOTER_SHARED, '0, '0);
        probe_khz = sb.khz_table[10];
        send_item(FUNC_REQUEST, VOTER_SHARED, '0, probe_khz);
        send_item(FUNC_REQUEST, VOTER_SHARED, '0, probe_khz - 1'b1);
        send_item(FUNC_RELEASE, VOTER_SHARED, '0, '0);
        send_item(FUNC_RELEASE, VOTER_OWNER, '0, '0);
        // Release with nobody attached leaves the count at zero.
        send_item(FUNC_RELEASE, VOTER_OWNER, IDX_MAX, KHZ_W'(KHZ_TOP));
        send_item(FUNC_QUERY, VOTER_SHARED, IDX_MAX, KHZ_W'(KHZ_TOP));

        // Random phases, each with its own level count and idle pattern.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_level_count(phase_count[p]);
            gap_percent = phase_idle[p % 4];
            load_table($urandom_range(3) != 0);
            random_traffic(ITEMS_PER_PHASE);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d transfers (%0d shared requests) and %0d checked results",
                 transfers, sb.shared_requests, sb.checked);
        $display("over %0d level-count writes including 0, 1, 32 and 63, in %0d cycles",
                 count_writes, cycle_count);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
